// File: design/sabbc_pkg.sv
// shared types and constants for the set associative buffer cache
`default_nettype none
package sabbc_pkg;
   localparam int SETS_DEFAULT = 1024;
   localparam int WAYS_DEFAULT = 4;
   localparam int SET_MAX_W    = 16;
   localparam int RANK_W       = 5;
   localparam logic [7:0] REF_MAX = 8'd255;

   typedef enum logic [1:0] {
      ACT_GET     = 2'd0,
      ACT_RELEASE = 2'd1,
      ACT_PIN     = 2'd2,
      ACT_UNPIN   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_BUFFER = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_SCAN,
      B_DONE
   } back_state_type;

   typedef struct packed {
      action_type             action;
      logic [7:0]             device;
      logic [31:0]            block;
      logic [RANK_W-1:0]      way;
      logic [SET_MAX_W-1:0]   set;
   } item_type;

   typedef struct packed {
      logic [7:0]        device;
      logic [31:0]       block;
      logic              valid;
      logic [7:0]        refs;
      logic [RANK_W-1:0] rank;
   } entry_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;
endpackage
`default_nettype wire

// File: design/sabbc_front.sv
// front end: takes a transaction, works out set and way, hands it to the queue
`default_nettype none
module sabbc_front #(
   parameter int SETS = sabbc_pkg::SETS_DEFAULT,
   parameter int WAYS = sabbc_pkg::WAYS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic [1:0]           action,
   input  wire logic [7:0]           device_id,
   input  wire logic [31:0]          block_number,
   input  wire logic [1:0]           way_index,
   output logic                      pending,
   output logic                      push,
   output sabbc_pkg::item_type       push_item,
   input  wire logic                 q_full
);
   import sabbc_pkg::*;

   localparam int  SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
   localparam bit  IS_POW2 = ((SETS & (SETS - 1)) == 0);
   // rounded-up reciprocal, exact quotient for any 32-bit block number
   localparam logic [32:0] RECIP =
      33'(((64'd1 << (32 + SET_W)) / 64'(SETS)) + 64'd1);

   logic              pend_ff, pend_in;
   logic              done_ff, done_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [SET_W-1:0]  rem_ff, rem_in;
   logic [64:0]       prod_ff, prod_in;
   item_type          hold_ff, hold_in;
   logic [31:0]       quot, low_prod;
   logic [2:0]        wred;

   always_comb begin
      wred = {1'b0, way_index};
      if (WAYS < 4) begin
         for (int k = 0; k < 3; k++) begin
            if (32'(wred) >= WAYS) wred = wred - 3'(WAYS);
         end
      end
   end

   assign quot     = 32'(prod_ff >> (32 + SET_W));
   assign low_prod = quot * 32'(SETS);
   assign push     = pend_ff && done_ff && !q_full;
   assign pending  = pend_ff;

   always_comb begin
      push_item     = hold_ff;
      push_item.set = SET_MAX_W'(rem_ff);
   end

   always_comb begin
      pend_in = pend_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      hold_in = hold_ff;
      if (accept) begin
         pend_in        = 1'b1;
         hold_in.action = action_type'(action);
         hold_in.device = device_id;
         hold_in.block  = block_number;
         hold_in.way    = RANK_W'(wred);
         hold_in.set    = '0;
         if (IS_POW2) begin
            done_in = 1'b1;
            rem_in  = SET_W'(block_number & 32'(SETS - 1));
         end else begin
            done_in = 1'b0;
            cnt_in  = 2'd2;
            rem_in  = '0;
         end
      end else if (pend_ff && !done_ff) begin
         if (cnt_ff == 2'd2) begin
            // reciprocal multiply gives the quotient of block by SETS
            prod_in = 65'(hold_ff.block) * 65'(RECIP);
            cnt_in  = 2'd1;
         end else begin
            // multiply back and subtract to get the remainder
            rem_in  = SET_W'(hold_ff.block - low_prod);
            cnt_in  = 2'd0;
            done_in = 1'b1;
         end
      end else if (push) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         pend_ff <= pend_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      hold_ff <= hold_in;
   end
endmodule
`default_nettype wire

// File: design/sabbc_queue.sv
// two entry queue between front and back
`default_nettype none
module sabbc_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  sabbc_pkg::item_type      push_item,
   input  wire logic                pop,
   output sabbc_pkg::item_type      head,
   output logic                     not_empty,
   output logic                     full
);
   import sabbc_pkg::*;

   item_type    slot_ff [2];
   logic        wr_ff, rd_ff;
   logic [1:0]  cnt_ff;

   assign head      = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
      if (push) slot_ff[wr_ff] <= push_item;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty))
      else $error("queue underflow");
endmodule
`default_nettype wire

// File: design/sabbc_back.sv
// back end: reads a set, scans its ways, writes the set back and reports
`default_nettype none
module sabbc_back #(
   parameter int SETS = sabbc_pkg::SETS_DEFAULT,
   parameter int WAYS = sabbc_pkg::WAYS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    q_valid,
   input  sabbc_pkg::item_type          q_item,
   output logic                         pop,
   output sabbc_pkg::back_status_type   status,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_result_way,
   output logic                         rsp_was_hit,
   output logic                         rsp_needs_read,
   output logic [7:0]                   rsp_ref_after,
   output logic [1:0]                   rsp_status
);
   import sabbc_pkg::*;

   localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

   entry_type [WAYS-1:0] mem [SETS];

   back_state_type       state_ff, state_in;
   logic [SET_W-1:0]     clr_ff, clr_in;
   item_type             cur_ff, cur_in;
   entry_type [WAYS-1:0] row_ff;
   logic [WAY_W-1:0]     scan_ff, scan_in;
   logic                 hf_ff, hf_in, ff_ff, ff_in;
   logic [WAY_W-1:0]     hw_ff, hw_in, fw_ff, fw_in;
   logic [RANK_W-1:0]    hr_ff, hr_in, fr_ff, fr_in;

   logic                 rv_ff;
   logic [1:0]           rway_ff, rway_in, rst_ff, rst_in;
   logic                 rhit_ff, rhit_in, rrd_ff, rrd_in;
   logic [7:0]           rref_ff, rref_in;

   logic                 wr_en, rd_en;
   logic [SET_W-1:0]     wr_addr;
   entry_type [WAYS-1:0] wr_row, new_row, reset_row;
   entry_type            e;
   logic                 match, last;
   logic [WAY_W-1:0]     tw;
   logic [7:0]           nref;

   assign e     = row_ff[scan_ff];
   assign match = !cur_ff.device[7] && (e.device == cur_ff.device)
                  && (e.block == cur_ff.block);
   assign last  = (scan_ff == WAY_W'(WAYS - 1));

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         reset_row[i]      = '0;
         reset_row[i].rank = RANK_W'(WAYS - 1 - i);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: if (clr_ff == SET_W'(SETS - 1)) state_in = B_IDLE;
         B_IDLE:  if (q_valid) state_in = B_SCAN;
         B_SCAN:  if (last) state_in = B_DONE;
         B_DONE:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop     = 1'b0;
      rd_en   = 1'b0;
      wr_en   = 1'b0;
      wr_addr = cur_ff.set[SET_W-1:0];
      clr_in  = clr_ff;
      cur_in  = cur_ff;
      scan_in = scan_ff;
      hf_in = hf_ff; hw_in = hw_ff; hr_in = hr_ff;
      ff_in = ff_ff; fw_in = fw_ff; fr_in = fr_ff;
      new_row = row_ff;
      rway_in = 2'd0; rhit_in = 1'b0; rrd_in = 1'b0; rref_in = 8'd0;
      rst_in  = ST_OK;
      tw      = '0;
      nref    = 8'd0;
      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
         end
         B_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               rd_en   = 1'b1;
               cur_in  = q_item;
               scan_in = '0;
               hf_in   = 1'b0;
               ff_in   = 1'b0;
            end
         end
         B_SCAN: begin
            if (match && (!hf_ff || e.rank < hr_ff)) begin
               hf_in = 1'b1; hw_in = scan_ff; hr_in = e.rank;
            end
            if (e.refs == 8'd0 && (!ff_ff || e.rank > fr_ff)) begin
               ff_in = 1'b1; fw_in = scan_ff; fr_in = e.rank;
            end
            scan_in = scan_ff + 1'b1;
         end
         B_DONE: begin
            wr_en = 1'b1;
            if (cur_ff.action == ACT_GET) begin
               if (hf_ff) begin
                  tw = hw_ff;
                  if (row_ff[tw].refs != REF_MAX) new_row[tw].refs = row_ff[tw].refs + 8'd1;
                  rhit_in = 1'b1;
                  rrd_in  = !row_ff[tw].valid;
                  new_row[tw].valid = 1'b1;
                  rref_in = new_row[tw].refs;
                  rway_in = 2'(tw);
               end else if (ff_ff) begin
                  tw = fw_ff;
                  new_row[tw].device = cur_ff.device;
                  new_row[tw].block  = cur_ff.block;
                  new_row[tw].valid  = 1'b1;
                  new_row[tw].refs   = 8'd1;
                  rrd_in  = 1'b1;
                  rref_in = 8'd1;
                  rway_in = 2'(tw);
               end else begin
                  rst_in = ST_NO_BUFFER;
               end
            end else begin
               tw      = cur_ff.way[WAY_W-1:0];
               rway_in = 2'(tw);
               if (cur_ff.action == ACT_PIN) begin
                  if (row_ff[tw].refs != REF_MAX) new_row[tw].refs = row_ff[tw].refs + 8'd1;
                  rref_in = new_row[tw].refs;
               end else if (row_ff[tw].refs == 8'd0) begin
                  rst_in = ST_UNDERFLOW;
               end else begin
                  nref = row_ff[tw].refs - 8'd1;
                  new_row[tw].refs = nref;
                  rref_in = nref;
                  if (cur_ff.action == ACT_RELEASE && nref == 8'd0) begin
                     // count fell to zero: entry becomes most recent
                     for (int i = 0; i < WAYS; i++) begin
                        if (row_ff[i].rank < row_ff[tw].rank)
                           new_row[i].rank = row_ff[i].rank + 1'b1;
                     end
                     new_row[tw].rank = '0;
                  end
               end
            end
         end
         default: ;
      endcase
      wr_row = (state_ff == B_CLEAR) ? reset_row : new_row;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_row;
      if (rd_en) row_ff <= mem[q_item.set[SET_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= (state_ff == B_DONE);
      end
      cur_ff  <= cur_in;
      scan_ff <= scan_in;
      hf_ff <= hf_in; hw_ff <= hw_in; hr_ff <= hr_in;
      ff_ff <= ff_in; fw_ff <= fw_in; fr_ff <= fr_in;
      rway_ff <= rway_in; rhit_ff <= rhit_in; rrd_ff <= rrd_in;
      rref_ff <= rref_in; rst_ff <= rst_in;
   end

   assign status.clearing = (state_ff == B_CLEAR);
   assign rsp_valid      = rv_ff;
   assign rsp_result_way = rway_ff;
   assign rsp_was_hit    = rhit_ff;
   assign rsp_needs_read = rrd_ff;
   assign rsp_ref_after  = rref_ff;
   assign rsp_status     = rst_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> $past(state_ff == B_DONE))
      else $error("response without finished set update");
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_SCAN && last) |=> state_ff == B_DONE)
      else $error("scan did not finish");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == B_IDLE && q_valid))
      else $error("pop outside idle");
endmodule
`default_nettype wire

// File: design/set_assoc_block_buffer_cache_core.sv
// top level of the set associative buffer cache tag store
// the back end reads a set, scans it way by way and writes it back before it takes the next transaction
// a non-power-of-two SETS adds a reciprocal multiply and a multiply-back remainder step in the front end
// after reset the tag memory is cleared one set a cycle, with busy high
// results cannot be stalled: each stays on rsp_ ports for one cycle with rsp_valid
`default_nettype none
module set_assoc_block_buffer_cache_core #(
   parameter int SETS = sabbc_pkg::SETS_DEFAULT,
   parameter int WAYS = sabbc_pkg::WAYS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [7:0]  req_device_id,
   input  wire logic [31:0]        req_block_number,
   input  wire logic [1:0]         req_way_index,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_result_way,
   output logic                    rsp_was_hit,
   output logic                    rsp_needs_read,
   output logic [7:0]              rsp_ref_after,
   output logic [1:0]              rsp_status
);
   import sabbc_pkg::*;

   logic            accept, pending, push, pop, q_full, q_valid;
   item_type        push_item, head;
   back_status_type bstat;

   // a transaction is taken when start meets an idle front end and the tag memory is not being cleared
   assign busy   = pending || bstat.clearing;
   assign accept = start && !busy;

   sabbc_front #(.SETS(SETS), .WAYS(WAYS)) u_front (
      .clock, .reset, .accept,
      .action(req_action), .device_id(req_device_id),
      .block_number(req_block_number), .way_index(req_way_index),
      .pending, .push, .push_item, .q_full
   );

   // decouples classification from the set update
   sabbc_queue u_queue (
      .clock, .reset, .push, .push_item, .pop,
      .head, .not_empty(q_valid), .full(q_full)
   );

   sabbc_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
      .clock, .reset, .q_valid, .q_item(head), .pop, .status(bstat),
      .rsp_valid, .rsp_result_way, .rsp_was_hit, .rsp_needs_read,
      .rsp_ref_after, .rsp_status
   );
endmodule
`default_nettype wire
